// ===== sv/date_normalizer_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Date normalizer assertion macros
// Concurrent checks sampled on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DATE_NORMALIZER_UNIT_MACROS_SVH
`define DATE_NORMALIZER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DNU_ASSERT_SAME_CYCLE(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("date normalizer check failed");

// Consequent must hold in the cycle after the antecedent.
`define DNU_ASSERT_NEXT_CYCLE(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("date normalizer check failed");

`endif

// ===== sv/dnu_pkg.sv =====
// ----------------------------------------------------------------------------
// Date normalizer package
// Widths, calendar constants, sequencer states and shared helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package dnu_pkg;

    // Width of the raw day field.
    localparam int DAY_BITS = 16;

    // Working day register: holds the 400-year day count and a month of margin.
    localparam int DAY_W = ((DAY_BITS > 18) ? DAY_BITS : 18) + 2;
    // Working year register: input year plus whole cycles folded out of the day.
    localparam int YEAR_W = (DAY_BITS > 26) ? DAY_BITS - 8 : 18;
    // Year-modulo register, wide enough to hold the raw year before reduction.
    localparam int YM_W = 16;
    // Signed step applied to the year by one step update (up to one full 400-year cycle).
    localparam int YEAR_OP_W = 10;

    localparam int IN_W = DAY_BITS + 8 + 16;
    localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W = 5 + 4 + 16 + 3;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
    localparam int OUT_PAD_W = OUT_TDATA_W - OUT_W;

    localparam int CYCLE_DAYS = 146097;
    localparam int CYCLE_YEARS = 400;
    localparam int CENTURY = 100;
    localparam int MONTHS = 12;

    // Restoring reduction of the year by 400 << k, k from MOD_STEPS-1 down to 0.
    localparam int MOD_STEPS = 7;
    localparam int K_W = $clog2(MOD_STEPS);

    localparam logic signed [DAY_W-1:0] CYC_DAYS_D = DAY_W'(CYCLE_DAYS);
    localparam logic signed [YEAR_OP_W-1:0] CYC_YEARS_Y = YEAR_OP_W'(CYCLE_YEARS);
    localparam logic [YM_W-1:0] YM_CYCLE = YM_W'(CYCLE_YEARS);
    localparam logic [YM_W-1:0] YM_LAST = YM_W'(CYCLE_YEARS - 1);
    localparam logic signed [7:0] MONTHS_S = 8'(MONTHS);
    localparam logic [3:0] MONTH_DEC = 4'(MONTHS);
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_JAN = 4'd1;

    typedef enum logic [2:0] {
        ERR_OK         = 3'd0,
        ERR_DAY_ZERO   = 3'd1,
        ERR_MONTH_ZERO = 3'd2,
        ERR_YEAR_LOW   = 3'd3,
        ERR_YEAR_OVF   = 3'd4
    } t_err;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_FOLD,
        ST_CYC,
        ST_WALK,
        ST_FIN
    } t_state;

    // Working context carried through the sequencer.
    typedef struct packed {
        logic signed [DAY_W-1:0]  day;
        logic signed [7:0]        month;
        logic signed [YEAR_W-1:0] year;
        logic [YM_W-1:0]          ym;
        logic [K_W-1:0]           k;
    } t_ctx;

    // Output beat, last member in the lowest bits.
    typedef struct packed {
        logic [OUT_PAD_W-1:0] pad;
        t_err                 error_code;
        logic signed [15:0]   norm_year;
        logic [3:0]           norm_month;
        logic [4:0]           norm_day;
    } t_result;

    localparam logic [4:0] MONTH_LEN [13] = '{
        5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // Leap test on the year reduced modulo 400.
    function automatic logic f_is_leap(input logic [8:0] ym);
        logic by4;
        logic century;
        by4 = (ym[1:0] == 2'd0);
        century = (ym == 9'(CENTURY)) || (ym == 9'(2 * CENTURY))
               || (ym == 9'(3 * CENTURY));
        return (by4 && !century) || (ym == 9'd0);
    endfunction

    function automatic logic [4:0] f_days_in(input logic [3:0] m, input logic leap);
        logic [3:0] idx;
        idx = (m == 4'd0) ? MONTH_JAN : ((m > MONTH_DEC) ? MONTH_DEC : m);
        if (m == MONTH_FEB && leap) begin
            return 5'd29;
        end
        return MONTH_LEN[idx];
    endfunction

endpackage

`default_nettype wire

// ===== sv/dnu_step.sv =====
// ----------------------------------------------------------------------------
// Date normalizer step unit
// One day adder and one year adder, steered by the sequencer phase.
// ----------------------------------------------------------------------------
`default_nettype none

module dnu_step (
    input  dnu_pkg::t_state i_state,
    input  dnu_pkg::t_ctx   i_ctx,
    output dnu_pkg::t_ctx   o_ctx,
    output logic            o_done
);
    import dnu_pkg::*;

    logic signed [DAY_W-1:0]     day;
    logic signed [DAY_W-1:0]     d_op;
    logic signed [7:0]           mon;
    logic signed [YEAR_W-1:0]    yr;
    logic signed [YEAR_OP_W-1:0] y_op;
    logic [YM_W-1:0]             ym;
    logic [YM_W-1:0]             ym_sub;
    logic                        ym_inc;
    logic                        ym_dec;
    logic                        leap;
    logic [3:0]                  m_cur;
    logic [3:0]                  m_prev;
    logic [4:0]                  len;
    logic [4:0]                  len_prev;

    always_comb begin
        day    = i_ctx.day;
        mon    = i_ctx.month;
        yr     = i_ctx.year;
        ym     = i_ctx.ym;
        o_ctx  = i_ctx;
        o_done = 1'b0;
        d_op   = '0;
        y_op   = '0;
        ym_inc = 1'b0;
        ym_dec = 1'b0;

        ym_sub   = YM_CYCLE << i_ctx.k;
        leap     = f_is_leap(ym[8:0]);
        m_cur    = mon[3:0];
        m_prev   = (m_cur == MONTH_JAN) ? MONTH_DEC : m_cur - 4'd1;
        len      = f_days_in(m_cur, leap);
        len_prev = f_days_in(m_prev, leap);

        case (i_state)
            ST_MOD: begin
                if (ym >= ym_sub) begin
                    o_ctx.ym = ym - ym_sub;
                end
                if (i_ctx.k == '0) begin
                    o_done = 1'b1;
                end else begin
                    o_ctx.k = i_ctx.k - K_W'(1);
                end
            end
            ST_FOLD: begin
                if (mon > MONTHS_S) begin
                    o_ctx.month = mon - MONTHS_S;
                    y_op = YEAR_OP_W'(1);
                    ym_inc = 1'b1;
                end else if (mon <= 8'sd0) begin
                    o_ctx.month = mon + MONTHS_S;
                    y_op = -YEAR_OP_W'(1);
                    ym_dec = 1'b1;
                end else begin
                    o_done = 1'b1;
                end
            end
            ST_CYC: begin
                if (day > CYC_DAYS_D) begin
                    d_op = -CYC_DAYS_D;
                    y_op = CYC_YEARS_Y;
                end else if (day <= -CYC_DAYS_D) begin
                    d_op = CYC_DAYS_D;
                    y_op = -CYC_YEARS_Y;
                end else begin
                    o_done = 1'b1;
                end
            end
            ST_WALK: begin
                if (day > $signed(DAY_W'(len))) begin
                    // Advance one month forward.
                    d_op = -$signed(DAY_W'(len));
                    if (m_cur == MONTH_DEC) begin
                        o_ctx.month = 8'sd1;
                        y_op = YEAR_OP_W'(1);
                        ym_inc = 1'b1;
                    end else begin
                        o_ctx.month = mon + 8'sd1;
                    end
                end else if (day <= $signed(DAY_W'(0))) begin
                    // Borrow the previous month.
                    d_op = $signed(DAY_W'(len_prev));
                    o_ctx.month = $signed(8'(m_prev));
                    if (m_cur == MONTH_JAN) begin
                        y_op = -YEAR_OP_W'(1);
                        ym_dec = 1'b1;
                    end
                end else begin
                    o_done = 1'b1;
                end
            end
            default: begin
                o_done = 1'b1;
            end
        endcase

        o_ctx.day  = day + d_op;
        o_ctx.year = yr + YEAR_W'(y_op);
        if (ym_inc) begin
            o_ctx.ym = (ym == YM_LAST) ? '0 : ym + YM_W'(1);
        end else if (ym_dec) begin
            o_ctx.ym = (ym == '0) ? YM_LAST : ym - YM_W'(1);
        end
    end

endmodule

`default_nettype wire

// ===== sv/date_normalizer_unit.sv =====
// ----------------------------------------------------------------------------
// Date normalizer unit
// Folds a raw day, month and year into a valid Gregorian date or an error.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_* takes one raw date per beat; master stream m_* returns
//   one result beat per input beat, in order. A beat failing the error checks
//   (day zero, month zero, year below one) goes straight to the result.
//   A good date runs a sequencer around one step unit: restoring steps
//   reduce the year modulo 400, then it folds the month into range one
//   fold at a time, removes whole 400-year day spans and walks month by
//   month, with a closing step for each of those three phases. Up to 11
//   folds and about 1080 months walked for a 16-bit day can occur; the
//   walk sets the worst case. s_tready is high only while idle, so the
//   next beat can be taken in the cycle after the result is handed off.
//   A stalled receiver holds the sequencer in its final state only while the
//   output register is still full. Reset (synchronous, active low) empties
//   the output register and returns the sequencer to idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "date_normalizer_unit_macros.svh"

module date_normalizer_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // raw_day[DAY_BITS], raw_month[8], raw_year[16], zero pad
    input  logic [dnu_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // norm_day[5], norm_month[4], norm_year[16], error_code[3], zero pad
    output logic [dnu_pkg::OUT_TDATA_W-1:0]    m_tdata
);
    import dnu_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_ctx    r_ctx;
    t_ctx    n_ctx;
    t_err    r_err;
    t_err    n_err;
    t_ctx    step_ctx;
    logic    step_done;
    logic    r_m_valid;
    t_result r_out;
    t_result n_out;
    logic    load_out;

    logic signed [DAY_BITS-1:0] raw_day;
    logic signed [7:0]          raw_month;
    logic signed [15:0]         raw_year;
    logic                       year_ovf;
    t_err                       fin_err;

    logic                       in_calendar;
    logic                       month_in_range;
    logic                       out_is_err;
    logic                       out_fields_zero;
    logic                       out_fields_ok;

    // Unpack the input beat.
    assign raw_day   = s_tdata[DAY_BITS-1:0];
    assign raw_month = s_tdata[DAY_BITS+7:DAY_BITS];
    assign raw_year  = s_tdata[DAY_BITS+23:DAY_BITS+8];

    dnu_step u_step (
        .i_state (r_state),
        .i_ctx   (r_ctx),
        .o_ctx   (step_ctx),
        .o_done  (step_done)
    );

    // Year leaves the 16-bit signed range when its upper bits disagree.
    assign year_ovf = (r_ctx.year[YEAR_W-1:15] != '0) && (r_ctx.year[YEAR_W-1:15] != '1);
    assign fin_err  = (r_err == ERR_OK && year_ovf) ? ERR_YEAR_OVF : r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_ctx    = r_ctx;
        n_err    = r_err;
        load_out = 1'b0;
        s_tready = 1'b0;
        n_out    = '0;

        case (r_state)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    n_ctx.day   = DAY_W'(raw_day);
                    n_ctx.month = raw_month;
                    n_ctx.year  = YEAR_W'(raw_year);
                    n_ctx.ym    = YM_W'(unsigned'(raw_year));
                    n_ctx.k     = K_W'(MOD_STEPS - 1);
                    if (raw_day == '0) begin
                        n_err = ERR_DAY_ZERO;
                    end else if (raw_month == 8'sd0) begin
                        n_err = ERR_MONTH_ZERO;
                    end else if (raw_year < 16'sd1) begin
                        n_err = ERR_YEAR_LOW;
                    end else begin
                        n_err = ERR_OK;
                    end
                    // Error beats skip the calendar work.
                    n_state = (n_err == ERR_OK) ? ST_MOD : ST_FIN;
                end
            end
            ST_MOD: begin
                n_ctx = step_ctx;
                if (step_done) begin
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                n_ctx = step_ctx;
                if (step_done) begin
                    n_state = ST_CYC;
                end
            end
            ST_CYC: begin
                n_ctx = step_ctx;
                if (step_done) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                n_ctx = step_ctx;
                if (step_done) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                n_out.error_code = fin_err;
                if (fin_err == ERR_OK) begin
                    n_out.norm_day   = r_ctx.day[4:0];
                    n_out.norm_month = r_ctx.month[3:0];
                    n_out.norm_year  = r_ctx.year[15:0];
                end
                // Hand off once the output register is free or draining.
                if (!r_m_valid || m_tready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ctx <= n_ctx;
        r_err <= n_err;
        if (load_out) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (load_out) begin
            r_m_valid <= 1'b1;
        end else if (m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_out;

    assign in_calendar     = r_state inside {ST_FOLD, ST_CYC, ST_WALK};
    assign month_in_range  = (r_ctx.month >= 8'sd1) && (r_ctx.month <= MONTHS_S);
    assign out_is_err      = (r_out.error_code != ERR_OK);
    assign out_fields_zero = (r_out.norm_day == 5'd0) && (r_out.norm_month == 4'd0)
                          && (r_out.norm_year == 16'sd0);
    assign out_fields_ok   = (r_out.norm_day != 5'd0) && (r_out.norm_month >= 4'd1)
                          && (r_out.norm_month <= MONTH_DEC);

    `DNU_ASSERT_SAME_CYCLE(a_walk_month, r_state == ST_WALK, month_in_range)
    `DNU_ASSERT_SAME_CYCLE(a_ym_reduced, in_calendar, r_ctx.ym < YM_CYCLE)
    `DNU_ASSERT_SAME_CYCLE(a_err_zero, r_m_valid && out_is_err, out_fields_zero)
    `DNU_ASSERT_SAME_CYCLE(a_ok_range, r_m_valid && !out_is_err, out_fields_ok)
    `DNU_ASSERT_NEXT_CYCLE(a_accept_start, s_tvalid && s_tready, r_state == ST_MOD || r_state == ST_FIN)

endmodule

`default_nettype wire
